[rtl/core/ecpa_pkg.sv]
// Types and opcodes shared by the affine point-add block.
// No dependencies.
`timescale 1ns / 1ps
package ecpa_pkg;
  localparam int W = 63;

  typedef struct packed {
    logic [W-1:0] first_x;
    logic [W-1:0] first_y;
    logic         first_infinite;
    logic [W-1:0] second_x;
    logic [W-1:0] second_y;
    logic         second_infinite;
  } in_req_t;

  typedef struct packed {
    logic [W-1:0] sum_x;
    logic [W-1:0] sum_y;
    logic         sum_infinite;
  } out_res_t;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_RED = 2'd1,
    OP_DIV = 2'd2
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_cmd_t;

  localparam logic [0:0] REG_CURVE_A = 1'b0;
  localparam logic [0:0] REG_MODULUS = 1'b1;
endpackage

[rtl/core/ecpa_seq_unit.sv]
// Shared sequential arithmetic unit: modular multiply (shift-add), reduction
// and integer divide (restoring), one bit per cycle. Depends on ecpa_pkg.
`timescale 1ns / 1ps
module ecpa_seq_unit #(
  parameter int FIELD_BITS = 63
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ecpa_pkg::alu_cmd_t    cmd,
  input  logic [FIELD_BITS-1:0] opa,
  input  logic [FIELD_BITS-1:0] opb,
  input  logic [FIELD_BITS-1:0] modulus,
  output logic                  done,
  output logic [FIELD_BITS-1:0] res_q,
  output logic [FIELD_BITS-1:0] res_r
);
  import ecpa_pkg::*;
  localparam int CW = $clog2(FIELD_BITS + 1);

  logic                  busy_r, busy_nxt;
  op_t                   op_r, op_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [FIELD_BITS-1:0] a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt, q_r, q_nxt;
  logic                  done_r, done_nxt;
  logic [FIELD_BITS:0]   sa, sd, rsh;
  logic [FIELD_BITS:0]   dsub;

  always_comb begin
    busy_nxt = busy_r; op_nxt = op_r; cnt_nxt = cnt_r;
    a_nxt = a_r; b_nxt = b_r; acc_nxt = acc_r; q_nxt = q_r; done_nxt = 1'b0;
    sa = '0; sd = '0; rsh = '0; dsub = '0;
    if (!busy_r && cmd.start) begin
      busy_nxt = 1'b1; op_nxt = cmd.op; cnt_nxt = CW'(FIELD_BITS);
      a_nxt = opa; b_nxt = opb; acc_nxt = '0; q_nxt = '0;
    end else if (busy_r) begin
      case (op_r)
        OP_MUL: begin
          // acc = 2*acc + (bit ? a : 0), MSB first, a < modulus
          sd = {acc_r, 1'b0};
          if (sd >= {1'b0, modulus}) sd = sd - {1'b0, modulus};
          sa = sd + (b_r[FIELD_BITS-1] ? {1'b0, a_r} : '0);
          if (sa >= {1'b0, modulus}) sa = sa - {1'b0, modulus};
          acc_nxt = sa[FIELD_BITS-1:0];
          b_nxt = {b_r[FIELD_BITS-2:0], 1'b0};
        end
        default: begin
          // restoring divide a_r by (RED ? modulus : b_r), remainder in acc
          rsh = {acc_r, a_r[FIELD_BITS-1]};
          dsub = rsh - {1'b0, (op_r == OP_RED) ? modulus : b_r};
          a_nxt = {a_r[FIELD_BITS-2:0], 1'b0};
          if (rsh >= {1'b0, (op_r == OP_RED) ? modulus : b_r}) begin
            acc_nxt = dsub[FIELD_BITS-1:0];
            q_nxt = {q_r[FIELD_BITS-2:0], 1'b1};
          end else begin
            acc_nxt = rsh[FIELD_BITS-1:0];
            q_nxt = {q_r[FIELD_BITS-2:0], 1'b0};
          end
        end
      endcase
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; op_r <= OP_MUL; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; op_r <= op_nxt; cnt_r <= cnt_nxt;
    end
    a_r <= a_nxt; b_r <= b_nxt; acc_r <= acc_nxt; q_r <= q_nxt;
  end

  assign done  = done_r;
  assign res_r = acc_r;
  assign res_q = q_r;
endmodule

[rtl/core/ec_affine_point_add_unit.sv]
// Top level of the affine point adder: config registers, sequencer, shared unit.
// Depends on ecpa_pkg and ecpa_seq_unit.
//
//  channel | ports                 | handshake
//  in      | start/busy, in_req    | start && !busy
//  out     | out_valid/out_result  | one-cycle strobe
//  cfg     | cfg_valid/cfg_ready   | valid && ready
//
// Every request first runs 5 reduction passes of the shared unit (inputs and a);
// pass-through and infinite cases end there. Addition and doubling add 3 passes
// per Euclid step (up to about 91 steps for a 63-bit modulus) and, when the
// denominator is invertible, 3 or 4 multiplies: 11 to about 280 passes in all.
// Reset clears the registers to a=0, p=3. The receiver cannot stall.
`timescale 1ns / 1ps
module ec_affine_point_add_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  ecpa_pkg::in_req_t     in_req,
  output logic                  out_valid,
  output ecpa_pkg::out_res_t    out_result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [0:0]            cfg_index,
  input  logic [ecpa_pkg::W-1:0] cfg_data
);
  import ecpa_pkg::*;
  localparam int F = W;

  typedef enum logic [20:0] {
    S_IDLE  = 21'd1 << 0,  S_RED   = 21'd1 << 1,  S_REDW  = 21'd1 << 2,
    S_CASE  = 21'd1 << 3,  S_MUL   = 21'd1 << 4,  S_MULW  = 21'd1 << 5,
    S_DEN   = 21'd1 << 6,  S_IDIV  = 21'd1 << 7,  S_IDIVW = 21'd1 << 8,
    S_IMUL  = 21'd1 << 9,  S_IMULW = 21'd1 << 10, S_IEND  = 21'd1 << 11,
    S_QRED  = 21'd1 << 12, S_QREDW = 21'd1 << 13, S_FIN   = 21'd1 << 14,
    S_OUT   = 21'd1 << 15, S_LAM   = 21'd1 << 16, S_X3    = 21'd1 << 17,
    S_Y3    = 21'd1 << 18, S_DONE  = 21'd1 << 19, S_SPARE = 21'd1 << 20
  } state_t;

  state_t        st_r, st_nxt;
  logic [F-1:0]  a_r, p_r, x1_r, y1_r, x2_r, y2_r;
  logic [F-1:0]  x1_nxt, y1_nxt, x2_nxt, y2_nxt;
  logic          i1_r, i2_r, dbl_r, dbl_nxt;
  logic [2:0]    ri_r, ri_nxt;
  logic [2:0]    mi_r, mi_nxt;
  logic [F-1:0]  t_r, t_nxt, num_r, num_nxt, lam_r, lam_nxt, x3_r, x3_nxt;
  logic [F-1:0]  r0_r, r0_nxt, r1_r, r1_nxt, t0_r, t0_nxt, t1_r, t1_nxt;
  logic [F-1:0]  q_r, q_nxt;
  out_res_t      res_r, res_nxt;
  logic          ov_r, ov_nxt;
  alu_cmd_t      cmd;
  logic [F-1:0]  opa, opb, pe;
  logic          udone;
  logic [F-1:0]  uq, ur;

  assign pe = (p_r < F'(3)) ? F'(3) : p_r;

  function automatic logic [F-1:0] fadd(logic [F-1:0] x, logic [F-1:0] y,
                                        logic [F-1:0] m);
    logic [F:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[F-1:0];
  endfunction

  function automatic logic [F-1:0] fsub(logic [F-1:0] x, logic [F-1:0] y,
                                        logic [F-1:0] m);
    return (x >= y) ? x - y : x + (m - y);
  endfunction

  ecpa_seq_unit #(.FIELD_BITS(F)) u_alu (
    .clk, .rst_n, .cmd, .opa, .opb, .modulus(pe),
    .done(udone), .res_q(uq), .res_r(ur)
  );

  always_comb begin
    st_nxt = st_r; x1_nxt = x1_r; y1_nxt = y1_r; x2_nxt = x2_r; y2_nxt = y2_r;
    dbl_nxt = dbl_r; ri_nxt = ri_r; mi_nxt = mi_r; t_nxt = t_r; num_nxt = num_r;
    lam_nxt = lam_r; x3_nxt = x3_r; r0_nxt = r0_r; r1_nxt = r1_r;
    t0_nxt = t0_r; t1_nxt = t1_r; q_nxt = q_r; res_nxt = res_r; ov_nxt = 1'b0;
    cmd = '{start: 1'b0, op: OP_MUL}; opa = '0; opb = '0;
    case (st_r)
      S_IDLE: if (start) begin
        x1_nxt = in_req.first_x; y1_nxt = in_req.first_y;
        x2_nxt = in_req.second_x; y2_nxt = in_req.second_y;
        ri_nxt = '0; st_nxt = S_RED;
      end
      S_RED: begin
        cmd = '{start: 1'b1, op: OP_RED};
        case (ri_r)
          3'd0: opa = x1_r;
          3'd1: opa = y1_r;
          3'd2: opa = x2_r;
          3'd3: opa = y2_r;
          default: opa = a_r;
        endcase
        st_nxt = S_REDW;
      end
      S_REDW: if (udone) begin
        case (ri_r)
          3'd0: x1_nxt = ur;
          3'd1: y1_nxt = ur;
          3'd2: x2_nxt = ur;
          3'd3: y2_nxt = ur;
          default: t_nxt = ur;
        endcase
        if (ri_r == 3'd4) st_nxt = S_CASE;
        else begin
          ri_nxt = ri_r + 3'd1; st_nxt = S_RED;
        end
      end
      S_CASE: begin
        res_nxt = '{sum_x: '0, sum_y: '0, sum_infinite: 1'b1};
        if (i1_r) begin
          if (!i2_r) res_nxt = '{sum_x: x2_r, sum_y: y2_r, sum_infinite: 1'b0};
          st_nxt = S_OUT;
        end else if (i2_r) begin
          res_nxt = '{sum_x: x1_r, sum_y: y1_r, sum_infinite: 1'b0};
          st_nxt = S_OUT;
        end else if (x1_r == x2_r) begin
          if (y1_r != y2_r || y1_r == '0) st_nxt = S_OUT;
          else begin
            dbl_nxt = 1'b1; mi_nxt = '0; st_nxt = S_MUL;
          end
        end else begin
          dbl_nxt = 1'b0;
          num_nxt = fsub(y2_r, y1_r, pe);
          r1_nxt = fsub(x2_r, x1_r, pe);
          st_nxt = S_DEN;
        end
      end
      S_MUL: begin
        cmd = '{start: 1'b1, op: OP_MUL};
        opa = x1_r; opb = x1_r;
        st_nxt = S_MULW;
      end
      S_MULW: if (udone) begin
        num_nxt = fadd(fadd(fadd(ur, ur, pe), ur, pe), t_r, pe);
        r1_nxt = fadd(y1_r, y1_r, pe);
        st_nxt = S_DEN;
      end
      S_DEN: begin
        r0_nxt = pe; t0_nxt = '0; t1_nxt = F'(1);
        st_nxt = (r1_r == '0) ? S_FIN : S_IDIV;
      end
      S_IDIV: begin
        cmd = '{start: 1'b1, op: OP_DIV}; opa = r0_r; opb = r1_r;
        st_nxt = S_IDIVW;
      end
      S_IDIVW: if (udone) begin
        q_nxt = uq; r0_nxt = r1_r; r1_nxt = ur; st_nxt = S_QRED;
      end
      S_QRED: begin
        cmd = '{start: 1'b1, op: OP_RED}; opa = q_r; st_nxt = S_QREDW;
      end
      S_QREDW: if (udone) begin
        q_nxt = ur; st_nxt = S_IMUL;
      end
      S_IMUL: begin
        cmd = '{start: 1'b1, op: OP_MUL}; opa = q_r; opb = t1_r;
        st_nxt = S_IMULW;
      end
      S_IMULW: if (udone) begin
        t0_nxt = t1_r; t1_nxt = fsub(t0_r, ur, pe); st_nxt = S_IEND;
      end
      S_IEND: st_nxt = (r1_r == '0) ? S_FIN : S_IDIV;
      S_FIN: begin
        if (r0_r != F'(1)) begin
          res_nxt = '{sum_x: '0, sum_y: '0, sum_infinite: 1'b1};
          st_nxt = S_OUT;
        end else st_nxt = S_LAM;
        mi_nxt = '0;
      end
      S_LAM: begin
        cmd = '{start: 1'b1, op: OP_MUL};
        case (mi_r)
          3'd0: begin opa = num_r; opb = t0_r; end
          3'd1: begin opa = lam_r; opb = lam_r; end
          default: begin opa = lam_r; opb = fsub(x1_r, x3_r, pe); end
        endcase
        st_nxt = S_X3;
      end
      S_X3: if (udone) begin
        case (mi_r)
          3'd0: begin
            lam_nxt = ur; mi_nxt = 3'd1; st_nxt = S_LAM;
          end
          3'd1: begin
            x3_nxt = dbl_r ? fsub(ur, fadd(x1_r, x1_r, pe), pe)
                           : fsub(fsub(ur, x1_r, pe), x2_r, pe);
            mi_nxt = 3'd2; st_nxt = S_LAM;
          end
          default: begin
            res_nxt = '{sum_x: x3_r, sum_y: fsub(ur, y1_r, pe), sum_infinite: 1'b0};
            st_nxt = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        ov_nxt = 1'b1; st_nxt = S_DONE;
      end
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0; a_r <= '0; p_r <= F'(3);
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CURVE_A) a_r <= cfg_data;
        else p_r <= cfg_data;
      end
    end
    if (st_r == S_IDLE && start) begin
      i1_r <= in_req.first_infinite; i2_r <= in_req.second_infinite;
    end
    x1_r <= x1_nxt; y1_r <= y1_nxt; x2_r <= x2_nxt; y2_r <= y2_nxt;
    dbl_r <= dbl_nxt; ri_r <= ri_nxt; mi_r <= mi_nxt; t_r <= t_nxt;
    num_r <= num_nxt; lam_r <= lam_nxt; x3_r <= x3_nxt; r0_r <= r0_nxt;
    r1_r <= r1_nxt; t0_r <= t0_nxt; t1_r <= t1_nxt; q_r <= q_nxt;
    res_r <= res_nxt;
  end

  assign busy       = (st_r != S_IDLE);
  assign cfg_ready  = (st_r == S_IDLE);
  assign out_valid  = ov_r;
  assign out_result = res_r;
endmodule

[rtl/core/ecpa_checker.sv]
// Port-level checks for the affine point adder, bound to the top level.
// Depends on ecpa_pkg.
`timescale 1ns / 1ps
module ecpa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input ecpa_pkg::out_res_t out_result,
  input logic               cfg_ready
);
  import ecpa_pkg::*;

  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request not taken");
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe too long");
  a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.sum_infinite) |->
      (out_result.sum_x == '0 && out_result.sum_y == '0))
    else $error("infinite result has nonzero coordinates");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !busy) else $error("config open while busy");
endmodule

bind ec_affine_point_add_unit ecpa_checker u_ecpa_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_result, .cfg_ready
);

[bench/tb.sv]
// Testbench for ec_affine_point_add_unit: drives point pairs and curve settings,
// predicts each sum in place and checks every result strobe against it.
// Depends on ecpa_pkg and the RTL of the point adder.
`timescale 1ns / 1ps
module tb;
  import ecpa_pkg::*;

  localparam int          FB        = 63;
  localparam logic [63:0] ALL_ONES  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [FB-1:0] MAX_X   = ALL_ONES[FB-1:0];
  localparam logic [63:0] BIG_PRIME = 64'd9223372036854775783;
  localparam int          IDLE_LIMIT = 100000;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  in_req_t         in_req = '0;
  logic            out_valid;
  out_res_t        out_result;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [0:0]      cfg_index = REG_CURVE_A;
  logic [FB-1:0]   cfg_data = '0;

  logic [63:0]     curve_a_q = 64'd0;
  logic [63:0]     modulus_q = 64'd3;
  out_res_t        sum_queue[$];
  int              mismatches = 0;
  int              idle_cycles = 0;

  ec_affine_point_add_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_result(out_result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] f_add(logic [63:0] a, logic [63:0] b, logic [63:0] p);
    logic [63:0] s;
    s = a + b;
    return (s >= p) ? s - p : s;
  endfunction

  function automatic logic [63:0] f_sub(logic [63:0] a, logic [63:0] b, logic [63:0] p);
    return (a >= b) ? a - b : a + (p - b);
  endfunction

  function automatic logic [63:0] f_mul(logic [63:0] a, logic [63:0] b, logic [63:0] p);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return 64'(prod % {64'd0, p});
  endfunction

  function automatic bit f_inv(logic [63:0] e, logic [63:0] p, output logic [63:0] inv);
    logic [63:0] r0, r1, r2, t0, t1, t2, q;
    r0 = p; r1 = e % p; t0 = 0; t1 = 1; inv = 0;
    while (r1 != 0) begin
      q = r0 / r1;
      r2 = r0 - q * r1;
      t2 = f_sub(t0, f_mul(q % p, t1, p), p);
      r0 = r1; r1 = r2; t0 = t1; t1 = t2;
    end
    inv = t0;
    return r0 == 1;
  endfunction

  function automatic out_res_t predict_sum(in_req_t r);
    logic [63:0] p, a, x1, y1, x2, y2, num, den, inv, lam, x3, y3;
    out_res_t res;
    p = modulus_q;
    if (p < 3) p = 3;
    a = curve_a_q % p;
    x1 = {1'b0, r.first_x} % p;
    y1 = {1'b0, r.first_y} % p;
    x2 = {1'b0, r.second_x} % p;
    y2 = {1'b0, r.second_y} % p;
    res = '0;
    res.sum_infinite = 1'b1;
    if (r.first_infinite) begin
      if (!r.second_infinite) begin
        res.sum_x = x2[FB-1:0]; res.sum_y = y2[FB-1:0]; res.sum_infinite = 1'b0;
      end
      return res;
    end
    if (r.second_infinite) begin
      res.sum_x = x1[FB-1:0]; res.sum_y = y1[FB-1:0]; res.sum_infinite = 1'b0;
      return res;
    end
    if (x1 == x2) begin
      if (y1 != y2 || y1 == 0) return res;
      num = f_add(f_mul(3, f_mul(x1, x1, p), p), a, p);
      den = f_add(y1, y1, p);
      if (!f_inv(den, p, inv)) return res;
      lam = f_mul(num, inv, p);
      x3 = f_sub(f_mul(lam, lam, p), f_add(x1, x1, p), p);
    end else begin
      num = f_sub(y2, y1, p);
      den = f_sub(x2, x1, p);
      if (!f_inv(den, p, inv)) return res;
      lam = f_mul(num, inv, p);
      x3 = f_sub(f_sub(f_mul(lam, lam, p), x1, p), x2, p);
    end
    y3 = f_sub(f_mul(lam, f_sub(x1, x3, p), p), y1, p);
    res.sum_x = x3[FB-1:0];
    res.sum_y = y3[FB-1:0];
    res.sum_infinite = 1'b0;
    return res;
  endfunction

  // accept a request; start stays high so back-to-back requests need no toggle
  task automatic send_points(in_req_t r);
    in_req <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sum_queue.push_back(predict_sum(r));
  endtask

  task automatic hold_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sum_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[FB-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_CURVE_A) curve_a_q = val & ALL_ONES;
    else modulus_q = val & ALL_ONES;
  endtask

  task automatic set_curve(logic [63:0] a, logic [63:0] p);
    drain();
    write_reg(REG_CURVE_A, a);
    write_reg(REG_MODULUS, p);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [62:0] rand_word();
    return 63'({$urandom, $urandom} & ALL_ONES);
  endfunction

  function automatic logic [62:0] rand_coord();
    logic [63:0] p;
    p = (modulus_q < 3) ? 64'd3 : modulus_q;
    if ($urandom_range(0, 4) == 0) return rand_word();
    return 63'({1'b0, rand_word()} % p);
  endfunction

  function automatic in_req_t make_pair(logic [62:0] x1, logic [62:0] y1, bit i1,
                                        logic [62:0] x2, logic [62:0] y2, bit i2);
    in_req_t r;
    r.first_x = x1; r.first_y = y1; r.first_infinite = i1;
    r.second_x = x2; r.second_y = y2; r.second_infinite = i2;
    return r;
  endfunction

  task automatic test_passthrough();
    send_points(make_pair(1, 2, 1'b1, 2, 1, 1'b0));
    send_points(make_pair(2, 1, 1'b0, 1, 1, 1'b1));
    send_points(make_pair(MAX_X, MAX_X, 1'b1, MAX_X, MAX_X, 1'b1));
    send_points(make_pair(MAX_X, MAX_X, 1'b0, 0, 0, 1'b1));
    send_points(make_pair(0, 0, 1'b1, MAX_X, MAX_X - 1'b1, 1'b0));
  endtask

  task automatic test_doubling();
    send_points(make_pair(5, 7, 1'b0, 5, 7, 1'b0));
    send_points(make_pair(5, 0, 1'b0, 5, 0, 1'b0));
    send_points(make_pair(5, 7, 1'b0, 5, 8, 1'b0));
    send_points(make_pair(MAX_X - 1'b1, MAX_X - 1'b1, 1'b0,
                          MAX_X - 1'b1, MAX_X - 1'b1, 1'b0));
    send_points(make_pair(0, 1, 1'b0, 0, 1, 1'b0));
  endtask

  task automatic test_addition();
    send_points(make_pair(1, 2, 1'b0, 3, 4, 1'b0));
    send_points(make_pair(0, 0, 1'b0, MAX_X - 1'b1, MAX_X - 1'b1, 1'b0));
    send_points(make_pair(MAX_X, 1, 1'b0, 0, 1, 1'b0));
    send_points(make_pair(7, 9, 1'b0, 7 + BIG_PRIME[62:0], 9, 1'b0));
    send_points(make_pair(11, 3, 1'b0, 14, 3, 1'b0));
  endtask

  task automatic test_random(int n);
    in_req_t r;
    int k;
    repeat (n) begin
      k = $urandom_range(0, 99);
      r = make_pair(rand_coord(), rand_coord(), 1'b0, rand_coord(), rand_coord(), 1'b0);
      if (k < 8) r.first_infinite = 1'b1;
      else if (k < 16) r.second_infinite = 1'b1;
      else if (k < 20) begin
        r.first_infinite = 1'b1; r.second_infinite = 1'b1;
      end else if (k < 42) begin
        r.second_x = r.first_x; r.second_y = r.first_y;
      end else if (k < 47) begin
        r.second_x = r.first_x;
      end else if (k < 52) begin
        r.second_x = 63'({1'b0, r.first_x} + modulus_q);
      end else if (k < 55) begin
        r = make_pair(rand_word(), rand_word(), $urandom_range(0, 1),
                      rand_word(), rand_word(), $urandom_range(0, 1));
      end
      send_points(r);
      hold_gap();
    end
  endtask

  always @(posedge clk) begin
    out_res_t exp_sum;
    if (rst_n && out_valid) begin
      if (sum_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_result);
      end else begin
        exp_sum = sum_queue.pop_front();
        if (out_result.sum_x !== exp_sum.sum_x || out_result.sum_y !== exp_sum.sum_y ||
            out_result.sum_infinite !== exp_sum.sum_infinite) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%0d y=%0d inf=%0b, got x=%0d y=%0d inf=%0b",
                     exp_sum.sum_x, exp_sum.sum_y, exp_sum.sum_infinite,
                     out_result.sum_x, out_result.sum_y, out_result.sum_infinite);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_passthrough();
    test_random(40);
    set_curve(ALL_ONES, BIG_PRIME);
    test_passthrough();
    test_doubling();
    test_addition();
    test_random(120);
    set_curve(2, 97);
    test_doubling();
    test_random(60);
    drain();
    test_random(60);
    set_curve(5, 0);
    test_random(60);
    set_curve(6, 15);
    test_addition();
    test_random(80);
    set_curve(0, ALL_ONES);
    test_random(80);
    set_curve(ALL_ONES - 1, 1000003);
    test_random(120);
    set_curve(1, 2);
    test_random(40);
    set_curve(3, 7);
    test_random(60);
    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && sum_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/core/ecpa_pkg.sv
rtl/core/ecpa_seq_unit.sv
rtl/core/ec_affine_point_add_unit.sv
rtl/core/ecpa_checker.sv
bench/tb.sv
